### hdl/lpd_pkg.sv
package lpd_pkg;

	// Design limits
	localparam int MAX_LEVELS       = 6;
	localparam int BEEP_INTERVAL_MS = 2000;

	// Field widths fixed by the interface
	localparam int NUM_THR  = 6;
	localparam int THR_W    = 16;
	localparam int LVL_W    = 3;
	localparam int TIMER_W  = 32;
	localparam int BEEP_W   = $clog2(BEEP_INTERVAL_MS + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLARITY  = 3'd0,
		REG_THR_COUNT = 3'd1,
		REG_THR_1     = 3'd2,
		REG_THR_2     = 3'd3,
		REG_THR_3     = 3'd4,
		REG_THR_4     = 3'd5,
		REG_THR_5     = 3'd6,
		REG_THR_6     = 3'd7
	} cfg_reg_t;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef logic [NUM_THR-1:0][THR_W-1:0] thr_arr_t;

	typedef struct packed {
		logic             polarity;
		logic [LVL_W-1:0] thr_count;
		thr_arr_t         thr;
	} cfg_t;

	typedef struct packed {
		logic               pressed;
		logic               released;
		logic [TIMER_W-1:0] press_duration;
		logic [LVL_W-1:0]   press_level;
		logic               max_reached;
		logic               short_beep;
		logic               long_beep;
	} res_t;

endpackage

### hdl/lpd_in_if.sv
interface lpd_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic pin_level;

	modport source (output valid, output cmd, output pin_level, input ready);
	modport sink (input valid, input cmd, input pin_level, output ready);
endinterface

### hdl/lpd_out_if.sv
interface lpd_out_if
	import lpd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               pressed;
	logic               released;
	logic [TIMER_W-1:0] press_duration;
	logic [LVL_W-1:0]   press_level;
	logic               max_reached;
	logic               short_beep;
	logic               long_beep;

	modport source (output valid, output pressed, output released, output press_duration,
		output press_level, output max_reached, output short_beep, output long_beep,
		input ready);
	modport sink (input valid, input pressed, input released, input press_duration,
		input press_level, input max_reached, input short_beep, input long_beep,
		output ready);
endinterface

### hdl/lpd_cfg_if.sv
interface lpd_cfg_if
	import lpd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/multi_level_long_press_detector_unit.sv
// Channel     Dir  Payload                                       Transaction
// item_in     in   cmd, pin_level                                valid & ready
// result_out  out  pressed, released, press_duration,            valid & ready
//                  press_level, max_reached, short_beep, long_beep
// cfg         in   index (0..7), data                            valid & ready
//
// One item per cycle sustained while result_out is ready. The result passes
// through the input register, then the step logic into the result register.
// The per-item step (timer update plus six parallel threshold compares) is the
// path that sets the cycle.
// arst_n clears all control and press state; thresholds and polarity reset to 0.
// A stalled result only holds the input register; cfg.ready is always high.
module multi_level_long_press_detector_unit
	import lpd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	lpd_in_if.sink    item_in,
	lpd_out_if.source result_out,
	lpd_cfg_if.sink   cfg
);

	cfg_t cfg_q;

	// Input stage
	logic valid_s1;
	logic cmd_s1;
	logic pin_s1;

	// Result stage
	logic out_valid_q;
	res_t res_q;

	res_t res_c;
	logic advance;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_POLARITY:  cfg_q.polarity  <= cfg.data[0];
				REG_THR_COUNT: cfg_q.thr_count <= cfg.data[LVL_W-1:0];
				REG_THR_1:     cfg_q.thr[0]    <= cfg.data[THR_W-1:0];
				REG_THR_2:     cfg_q.thr[1]    <= cfg.data[THR_W-1:0];
				REG_THR_3:     cfg_q.thr[2]    <= cfg.data[THR_W-1:0];
				REG_THR_4:     cfg_q.thr[3]    <= cfg.data[THR_W-1:0];
				REG_THR_5:     cfg_q.thr[4]    <= cfg.data[THR_W-1:0];
				REG_THR_6:     cfg_q.thr[5]    <= cfg.data[THR_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the step fires when a held item can move into a free or
	// draining result register.
	// ------------------------------------------------------------------
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.valid && item_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			cmd_s1 <= item_in.cmd;
			pin_s1 <= item_in.pin_level;
		end
	end

	// ------------------------------------------------------------------
	// Press state and step logic
	// ------------------------------------------------------------------
	lpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.pin    (pin_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.pressed        = res_q.pressed;
	assign result_out.released       = res_q.released;
	assign result_out.press_duration = res_q.press_duration;
	assign result_out.press_level    = res_q.press_level;
	assign result_out.max_reached    = res_q.max_reached;
	assign result_out.short_beep     = res_q.short_beep;
	assign result_out.long_beep      = res_q.long_beep;

endmodule

### hdl/lpd_thr_cmp.sv
module lpd_thr_cmp
	import lpd_pkg::*;
(
	input  logic [TIMER_W-1:0] timer,
	input  thr_arr_t           thr,
	input  logic [LVL_W-1:0]   count,
	output logic [LVL_W-1:0]   level
);

	logic [MAX_LEVELS-1:0] hit;
	logic                  timer_hi;

	assign timer_hi = |timer[TIMER_W-1:THR_W];

	// Parallel comparators, one per level
	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++) begin
			hit[i] = timer_hi || (timer[THR_W-1:0] >= thr[i]);
		end
	end

	// Highest level in use that is met
	always_comb begin
		level = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (hit[i] && (LVL_W'(i) < count)) begin
				level = LVL_W'(i + 1);
			end
		end
	end

endmodule

### hdl/lpd_core.sv
module lpd_core
	import lpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic cmd,
	input  logic pin,
	input  cfg_t cfg,
	output res_t res
);

	logic               last_pin_q;
	logic               active_q;
	logic [TIMER_W-1:0] timer_q;
	logic [TIMER_W-1:0] dur_q;
	logic [LVL_W-1:0]   level_q;
	logic               max_q;
	logic [LVL_W-1:0]   notified_q;
	logic [BEEP_W-1:0]  beep_q;

	logic               last_pin_d;
	logic               active_d;
	logic [TIMER_W-1:0] timer_d;
	logic [TIMER_W-1:0] dur_d;
	logic [LVL_W-1:0]   level_d;
	logic               max_d;
	logic [LVL_W-1:0]   notified_d;
	logic [BEEP_W-1:0]  beep_d;

	logic [LVL_W-1:0]   count;
	logic [LVL_W-1:0]   new_level;
	logic               pressed_now;
	logic               rel;
	logic               sbeep;
	logic               lbeep;

	assign count = (cfg.thr_count > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : cfg.thr_count;

	lpd_thr_cmp u_thr_cmp (
		.timer (timer_d),
		.thr   (cfg.thr),
		.count (count),
		.level (new_level)
	);

	// Press timer: restarts on a new press, saturates while held
	always_comb begin
		timer_d = timer_q;
		if (cmd != CMD_CLEAR) begin
			if (pin != last_pin_q) begin
				if (pin == cfg.polarity) begin
					timer_d = '0;
				end
			end else if (active_q && (pin == cfg.polarity)) begin
				if (timer_q != '1) begin
					timer_d = timer_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		last_pin_d  = last_pin_q;
		active_d    = active_q;
		dur_d       = dur_q;
		level_d     = level_q;
		max_d       = max_q;
		notified_d  = notified_q;
		beep_d      = beep_q;
		rel         = 1'b0;
		sbeep       = 1'b0;
		lbeep       = 1'b0;
		pressed_now = (last_pin_q == cfg.polarity);

		if (cmd == CMD_CLEAR) begin
			level_d = '0;
			dur_d   = '0;
			max_d   = 1'b0;
		end else begin
			if (beep_q < BEEP_W'(BEEP_INTERVAL_MS)) begin
				beep_d = beep_q + 1'b1;
			end

			if (pin != last_pin_q) begin
				last_pin_d = pin;
				if (pin == cfg.polarity) begin
					active_d = 1'b1;
				end else if (active_q) begin
					dur_d    = timer_q;
					active_d = 1'b0;
					rel      = 1'b1;
				end
			end

			pressed_now = (pin == cfg.polarity);

			// released implies not pressed, so no extra check needed
			if (pressed_now && active_d) begin
				if (new_level > level_q) begin
					level_d = new_level;
				end
				if (level_d == count) begin
					max_d = 1'b1;
				end
			end

			if (pressed_now) begin
				if (level_d != '0) begin
					if (level_d != notified_q) begin
						sbeep      = 1'b1;
						notified_d = level_d;
					end
					if (max_d && (beep_d >= BEEP_W'(BEEP_INTERVAL_MS))) begin
						lbeep  = 1'b1;
						beep_d = '0;
					end
				end
			end else begin
				notified_d = '0;
			end
		end
	end

	always_comb begin
		res.pressed        = pressed_now;
		res.released       = rel;
		res.press_duration = dur_d;
		res.press_level    = level_d;
		res.max_reached    = max_d;
		res.short_beep     = sbeep;
		res.long_beep      = lbeep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pin_q <= 1'b1;
			active_q   <= 1'b0;
			timer_q    <= '0;
			dur_q      <= '0;
			level_q    <= '0;
			max_q      <= 1'b0;
			notified_q <= '0;
			beep_q     <= BEEP_W'(BEEP_INTERVAL_MS);
		end else if (step) begin
			last_pin_q <= last_pin_d;
			active_q   <= active_d;
			timer_q    <= timer_d;
			dur_q      <= dur_d;
			level_q    <= level_d;
			max_q      <= max_d;
			notified_q <= notified_d;
			beep_q     <= beep_d;
		end
	end

endmodule
